@@ rtl/core/kec_pkg.sv @@
// ----------------------------------------------------------------------------
// kec_pkg: shared types and constants of the key entropy checker
// Request and result structs, status and register codes, and the
// elaboration-time builder of the c*log2(c) table.
// ----------------------------------------------------------------------------
package kec_pkg;

  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned NUM_BINS     = 256;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 9;
  localparam int unsigned ZERO_TOTAL_W = 6;
  // 32 * entropy deficit against ratio * n: entropy/8 in 1/256 units
  localparam int unsigned RATIO_SHIFT  = 5;

  localparam logic [CFG_DATA_W-1:0] MIN_RATIO_RST  = 9'd128;
  localparam logic [CFG_DATA_W-1:0] ZERO_LIMIT_RST = 9'd8;

  typedef enum logic [1:0] {
    STATUS_VALID       = 2'd0,
    STATUS_BAD_LENGTH  = 2'd1,
    STATUS_ZERO_BYTES  = 2'd2,
    STATUS_LOW_ENTROPY = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_ENTROPY = 2'd0,
    CFG_ZERO_LIMIT  = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [BYTE_W-1:0] key_byte;
    logic              last_byte;
  } in_t;

  typedef struct packed {
    status_e                 status;
    logic [ZERO_TOTAL_W-1:0] zero_total;
  } out_t;

  // log2(c) with 32 fractional bits, bitwise squaring, truncating
  function automatic logic [63:0] log2_q32(input int unsigned c);
    logic [63:0] x;
    logic [63:0] frac;
    int unsigned k;
    int i;
    x    = '0;
    frac = '0;
    k    = 0;
    if (c <= 1) begin
      return '0;
    end
    for (i = 1; i < 32; i++) begin
      if ((c >> i) != 0) begin
        k = i;
      end
    end
    x = 64'(c) << (31 - k);
    for (i = 0; i < 32; i++) begin
      x    = (x * x) >> 31;
      frac = frac << 1;
      if (x >= 64'h0000_0001_0000_0000) begin
        frac[0] = 1'b1;
        x       = x >> 1;
      end
    end
    return (64'(k) << 32) | frac;
  endfunction

  // c*log2(c) rounded to frac_bits fractional bits
  function automatic logic [63:0] clog_entry(input int unsigned c,
                                             input int unsigned frac_bits);
    logic [63:0] p;
    p = '0;
    if (c <= 1) begin
      return '0;
    end
    p = 64'(c) * log2_q32(c);
    return (p + (64'd1 << (31 - frac_bits))) >> (32 - frac_bits);
  endfunction

endpackage

@@ rtl/core/kec_ram.sv @@
// ----------------------------------------------------------------------------
// kec_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle, read enable holds the data.
// ----------------------------------------------------------------------------
module kec_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/key_entropy_checker_core.sv @@
// ----------------------------------------------------------------------------
// key_entropy_checker_core: byte histogram entropy check of a key
// Output: a key's last byte passes s1, then its status lands in the result
// register; it waits in s1 while an earlier status waits on the result channel.
// Throughput: 1 byte per cycle unless a last byte waits in s1, bound by the
// bin count RAM read-modify-write (read at request time, written back from s1 with forwarding).
// Reset: control state, counts and registers go to their defaults at once;
// bin counts are not cleared, per-bin used flags mark them invalid.
// ----------------------------------------------------------------------------
module key_entropy_checker_core #(
  parameter int unsigned KEY_BYTES = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  kec_pkg::in_t                     in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output kec_pkg::out_t                    out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [kec_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [kec_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned CNT_MAX   = KEY_BYTES + 1;
  localparam int unsigned CNT_W     = $clog2(KEY_BYTES + 2);
  localparam int unsigned TAB_DEPTH = 2 ** CNT_W;
  localparam int unsigned TAB_W     = CNT_W + $clog2(CNT_W) + FRAC_BITS + 1;
  localparam int unsigned SUM_W     = TAB_W + kec_pkg::BYTE_W;
  localparam int unsigned REM_W     = SUM_W + 1;
  localparam int unsigned NB_W      = $clog2(KEY_BYTES + 1);
  localparam int unsigned R_W       = kec_pkg::CFG_DATA_W + NB_W + FRAC_BITS;
  localparam int unsigned CMP_W     = REM_W + kec_pkg::RATIO_SHIFT + R_W;
  localparam int unsigned LIM_W     = CNT_W + kec_pkg::CFG_DATA_W;
  localparam int unsigned ZX_W      = CNT_W + kec_pkg::ZERO_TOTAL_W;
  localparam int unsigned BYTE_W    = kec_pkg::BYTE_W;

  localparam logic [CNT_W-1:0] CNT_SAT  = CNT_W'(CNT_MAX);
  localparam logic [CNT_W-1:0] CNT_KEY  = CNT_W'(KEY_BYTES);
  localparam logic [TAB_W-1:0] T_FULL   = TAB_W'(kec_pkg::clog_entry(KEY_BYTES, FRAC_BITS));
  localparam logic signed [REM_W-1:0] REM_RST = $signed(REM_W'(T_FULL));

  // per-count increment of c*log2(c), zero once a bin is saturated
  logic [TAB_W-1:0] delta_tab [TAB_DEPTH];

  for (genvar g = 0; g < TAB_DEPTH; g++) begin : g_delta
    if (g < CNT_MAX) begin : g_step
      localparam logic [63:0] TLO = kec_pkg::clog_entry(g, FRAC_BITS);
      localparam logic [63:0] THI = kec_pkg::clog_entry(g + 1, FRAC_BITS);
      assign delta_tab[g] = TAB_W'(THI - TLO);
    end else begin : g_sat
      assign delta_tab[g] = '0;
    end
  end

  // registers
  logic [kec_pkg::CFG_DATA_W-1:0] ratio_q, ratio_d;
  logic [kec_pkg::CFG_DATA_W-1:0] zlim_q, zlim_d;
  logic                           s1_valid_q, s1_valid_d;
  kec_pkg::in_t                   s1_q, s1_d;
  logic [kec_pkg::NUM_BINS-1:0]   used_q, used_d;
  logic [CNT_W-1:0]               bt_q, bt_d;
  logic [CNT_W-1:0]               zc_q, zc_d;
  logic signed [REM_W-1:0]        rem_q, rem_d;
  logic [BYTE_W-1:0]              fw_byte_q, fw_byte_d;
  logic [CNT_W-1:0]               fw_cnt_q, fw_cnt_d;
  logic                           out_valid_q, out_valid_d;
  kec_pkg::out_t                  out_q, out_d;

  // datapath
  logic              in_acc;
  logic              s1_adv;
  logic [CNT_W-1:0]  ram_rdata;
  logic [CNT_W-1:0]  old_cnt;
  logic [CNT_W-1:0]  new_cnt;
  logic [TAB_W-1:0]  delta;
  logic              zero_over;
  logic              low_ent;
  logic [R_W-1:0]    rhs;
  logic [CMP_W-1:0]  lhs_base;
  logic [CMP_W-1:0]  lhs;
  logic [ZX_W-1:0]   zc_ext;
  kec_pkg::status_e  status;

  assign s1_adv      = s1_valid_q && (!s1_q.last_byte || !out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || s1_adv;
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  kec_ram #(
    .WIDTH (CNT_W),
    .DEPTH (kec_pkg::NUM_BINS)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_q.key_byte),
    .wdata_i (new_cnt),
    .re_i    (in_acc),
    .raddr_i (in_data_i.key_byte),
    .rdata_o (ram_rdata)
  );

  // bin lookup: unused bins count zero, last write wins over stale read data
  always_comb begin
    if (!used_q[s1_q.key_byte]) begin
      old_cnt = '0;
    end else if (fw_byte_q == s1_q.key_byte) begin
      old_cnt = fw_cnt_q;
    end else begin
      old_cnt = ram_rdata;
    end
    new_cnt = (old_cnt < CNT_SAT) ? old_cnt + 1'b1 : old_cnt;
    delta   = delta_tab[old_cnt];
  end

  // running counts after this byte
  always_comb begin
    bt_d  = (bt_q < CNT_SAT) ? bt_q + 1'b1 : bt_q;
    zc_d  = zc_q;
    if ((s1_q.key_byte == '0) && (zc_q < CNT_SAT)) begin
      zc_d = zc_q + 1'b1;
    end
    rem_d = rem_q - $signed(REM_W'(delta));
  end

  // verdict
  always_comb begin
    rhs       = (R_W'(ratio_q) * R_W'(KEY_BYTES)) << FRAC_BITS;
    zero_over = LIM_W'(zc_d) > LIM_W'(zlim_q);
    lhs_base  = CMP_W'($unsigned(rem_d));
    lhs       = lhs_base << kec_pkg::RATIO_SHIFT;
    // negative remainder means the deficit clamps to zero
    if (rem_d[REM_W-1]) begin
      low_ent = (rhs != '0);
    end else begin
      low_ent = lhs < CMP_W'(rhs);
    end
    if (bt_d != CNT_KEY) begin
      status = kec_pkg::STATUS_BAD_LENGTH;
    end else if (zero_over) begin
      status = kec_pkg::STATUS_ZERO_BYTES;
    end else if (low_ent) begin
      status = kec_pkg::STATUS_LOW_ENTROPY;
    end else begin
      status = kec_pkg::STATUS_VALID;
    end
    zc_ext = ZX_W'(zc_d);
  end

  // next state
  always_comb begin
    ratio_d     = ratio_q;
    zlim_d      = zlim_q;
    s1_valid_d  = s1_valid_q;
    s1_d        = s1_q;
    used_d      = used_q;
    fw_byte_d   = fw_byte_q;
    fw_cnt_d    = fw_cnt_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (cfg_valid_i) begin
      case (cfg_index_i)
        kec_pkg::CFG_MIN_ENTROPY: ratio_d = cfg_data_i;
        kec_pkg::CFG_ZERO_LIMIT:  zlim_d  = cfg_data_i;
        default: ;
      endcase
    end

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (in_acc) begin
      s1_valid_d = 1'b1;
      s1_d       = in_data_i;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end

    if (s1_adv) begin
      fw_byte_d = s1_q.key_byte;
      fw_cnt_d  = new_cnt;
      if (s1_q.last_byte) begin
        used_d           = '0;
        out_valid_d      = 1'b1;
        out_d.status     = status;
        out_d.zero_total = zc_ext[kec_pkg::ZERO_TOTAL_W-1:0];
      end else begin
        used_d[s1_q.key_byte] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q     <= kec_pkg::MIN_RATIO_RST;
      zlim_q      <= kec_pkg::ZERO_LIMIT_RST;
      s1_valid_q  <= 1'b0;
      used_q      <= '0;
      bt_q        <= '0;
      zc_q        <= '0;
      rem_q       <= REM_RST;
      out_valid_q <= 1'b0;
    end else begin
      ratio_q     <= ratio_d;
      zlim_q      <= zlim_d;
      s1_valid_q  <= s1_valid_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
      if (s1_adv) begin
        if (s1_q.last_byte) begin
          bt_q  <= '0;
          zc_q  <= '0;
          rem_q <= REM_RST;
        end else begin
          bt_q  <= bt_d;
          zc_q  <= zc_d;
          rem_q <= rem_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q      <= s1_d;
    fw_byte_q <= fw_byte_d;
    fw_cnt_q  <= fw_cnt_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ tb/sv/key_entropy_checker_core_tb.sv @@
// ----------------------------------------------------------------------------
// key_entropy_checker_core_tb: self-checking bench of the key entropy checker
// Streams keys byte by byte through the request channel and checks each
// verdict against an in-bench histogram predictor or a typed-in verdict. A
// table of directed keys comes first, followed by random keys over several
// register settings. Both sides of the stream idle and stall at random.
// ----------------------------------------------------------------------------
module key_entropy_checker_core_tb;

  localparam int unsigned KEY_BYTES      = 32;
  localparam int unsigned FRAC_BITS      = 16;
  localparam int unsigned CNT_SAT        = KEY_BYTES + 1;
  localparam int unsigned CLK_PERIOD     = 12;
  localparam int unsigned RESET_CYCLES   = 9;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned TIMEOUT_CYCLES = 200000;
  localparam int unsigned RANDOM_ITEMS   = 550;
  localparam int unsigned MIN_RAND_KEYS  = 18;
  localparam int unsigned KEYS_PER_PHASE = 3;
  localparam int unsigned NUM_DIRECTED   = 11;

  // register indexes the block decodes to nothing
  localparam logic [kec_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [kec_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef enum logic [2:0] {
    GEN_FILL,
    GEN_RAMP,
    GEN_ZERO_HEAD,
    GEN_UNIFORM,
    GEN_ALPHABET,
    GEN_ZERO_MIX
  } key_gen_e;

  typedef struct packed {
    int unsigned   len;
    key_gen_e      gen;
    logic [7:0]    base;
    int unsigned   arg;
    bit            typed;
    kec_pkg::out_t verdict;
  } key_row_t;

  // verdicts typed in where they follow directly from the reset registers
  localparam key_row_t DIRECTED_KEYS [NUM_DIRECTED] = '{
    '{1, GEN_FILL, 8'hFF, 0, 1'b1, '{kec_pkg::STATUS_BAD_LENGTH, 6'd0}},
    '{1, GEN_FILL, 8'h00, 0, 1'b1, '{kec_pkg::STATUS_BAD_LENGTH, 6'd1}},
    '{KEY_BYTES, GEN_RAMP, 8'h80, 1, 1'b1, '{kec_pkg::STATUS_VALID, 6'd0}},
    '{KEY_BYTES, GEN_FILL, 8'hFF, 0, 1'b1, '{kec_pkg::STATUS_LOW_ENTROPY, 6'd0}},
    '{KEY_BYTES, GEN_FILL, 8'h00, 0, 1'b1,
      '{kec_pkg::STATUS_ZERO_BYTES, 6'(KEY_BYTES)}},
    '{KEY_BYTES + 1, GEN_FILL, 8'h01, 0, 1'b1, '{kec_pkg::STATUS_BAD_LENGTH, 6'd0}},
    '{KEY_BYTES + 8, GEN_FILL, 8'h00, 0, 1'b1,
      '{kec_pkg::STATUS_BAD_LENGTH, 6'(CNT_SAT)}},
    '{KEY_BYTES - 1, GEN_RAMP, 8'hF0, 1, 1'b1, '{kec_pkg::STATUS_BAD_LENGTH, 6'd1}},
    '{KEY_BYTES, GEN_ZERO_HEAD, 8'h01, 8, 1'b0, '{kec_pkg::STATUS_VALID, 6'd0}},
    '{KEY_BYTES, GEN_ZERO_HEAD, 8'h01, 9, 1'b1, '{kec_pkg::STATUS_ZERO_BYTES, 6'd9}},
    '{KEY_BYTES, GEN_UNIFORM, 8'h00, 0, 1'b0, '{kec_pkg::STATUS_VALID, 6'd0}}
  };

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_valid   = 1'b0;
  logic                           in_ready;
  kec_pkg::in_t                   in_data    = '0;
  logic                           out_valid;
  logic                           out_ready  = 1'b0;
  kec_pkg::out_t                  out_data;
  logic                           cfg_valid  = 1'b0;
  logic                           cfg_ready;
  logic [kec_pkg::CFG_IDX_W-1:0]  cfg_index  = kec_pkg::CFG_MIN_ENTROPY;
  logic [kec_pkg::CFG_DATA_W-1:0] cfg_data   = '0;

  key_entropy_checker_core #(
    .KEY_BYTES(KEY_BYTES),
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // predictor state
  longint unsigned                clog_tab [CNT_SAT + 1];
  int unsigned                    bin_count [kec_pkg::NUM_BINS];
  bit                             bin_used [kec_pkg::NUM_BINS];
  int unsigned                    byte_total;
  int unsigned                    zero_count;
  longint unsigned                clog_sum;
  logic [kec_pkg::CFG_DATA_W-1:0] min_ratio  = kec_pkg::MIN_RATIO_RST;
  logic [kec_pkg::CFG_DATA_W-1:0] zero_limit = kec_pkg::ZERO_LIMIT_RST;

  kec_pkg::out_t verdict_q [$];

  int unsigned fail_count;
  int unsigned keys_sent;
  int unsigned bytes_sent;
  int unsigned settings_used;
  int unsigned status_seen [4];
  int unsigned burst_left;

  // c*log2(c) with FRAC_BITS fraction bits; mantissa squared bit by bit
  function automatic longint unsigned c_log_c(input int unsigned c);
    logic [63:0] mant;
    logic [31:0] fraction;
    int unsigned ipart;
    logic [63:0] prod;
    if (c < 2) begin
      return 0;
    end
    ipart    = $clog2(c + 1) - 1;
    mant     = 64'(c) << (31 - ipart);
    fraction = '0;
    repeat (32) begin
      mant     = (mant * mant) >> 31;
      fraction = {fraction[30:0], mant[32]};
      if (mant[32]) begin
        mant = mant >> 1;
      end
    end
    prod = 64'(c) * {ipart, fraction};
    return (prod + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
  endfunction

  function automatic void clear_histogram();
    foreach (bin_used[i]) begin
      bin_used[i] = 1'b0;
    end
    byte_total = 0;
    zero_count = 0;
    clog_sum   = 0;
  endfunction

  function automatic void predict_key_byte(input kec_pkg::in_t item, input bit typed,
                                           input kec_pkg::out_t typed_verdict);
    int unsigned     cnt;
    kec_pkg::out_t   verdict;
    longint unsigned deficit;
    longint unsigned floor_val;
    cnt = bin_used[item.key_byte] ? bin_count[item.key_byte] : 0;
    // a saturated bin no longer moves the sum
    if (cnt < CNT_SAT) begin
      clog_sum += clog_tab[cnt + 1] - clog_tab[cnt];
      cnt++;
    end
    bin_count[item.key_byte] = cnt;
    bin_used[item.key_byte]  = 1'b1;
    if (byte_total < CNT_SAT) begin
      byte_total++;
    end
    if (item.key_byte == 8'h00 && zero_count < CNT_SAT) begin
      zero_count++;
    end
    if (!item.last_byte) begin
      return;
    end
    verdict.zero_total = 6'(zero_count);
    if (byte_total != KEY_BYTES) begin
      verdict.status = kec_pkg::STATUS_BAD_LENGTH;
    end else if (zero_count > zero_limit) begin
      verdict.status = kec_pkg::STATUS_ZERO_BYTES;
    end else begin
      deficit   = (clog_tab[KEY_BYTES] > clog_sum) ? clog_tab[KEY_BYTES] - clog_sum : 0;
      floor_val = (64'(min_ratio) * KEY_BYTES) << FRAC_BITS;
      if ((deficit << kec_pkg::RATIO_SHIFT) < floor_val) begin
        verdict.status = kec_pkg::STATUS_LOW_ENTROPY;
      end else begin
        verdict.status = kec_pkg::STATUS_VALID;
      end
    end
    verdict_q.push_back(typed ? typed_verdict : verdict);
    clear_histogram();
  endfunction

  task automatic send_byte(input kec_pkg::in_t item, input bit typed,
                           input kec_pkg::out_t typed_verdict);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    bytes_sent++;
    predict_key_byte(item, typed, typed_verdict);
  endtask

  task automatic send_key(input int unsigned len, input key_gen_e gen,
                          input logic [7:0] base, input int unsigned arg,
                          input bit typed, input kec_pkg::out_t typed_verdict);
    logic [7:0]   alphabet [12];
    kec_pkg::in_t item;
    foreach (alphabet[i]) begin
      alphabet[i] = 8'($urandom);
    end
    if ($urandom_range(0, 2) == 0) begin
      alphabet[0] = 8'h00;
    end
    for (int i = 0; i < len; i++) begin
      case (gen)
        GEN_FILL:      item.key_byte = base;
        GEN_RAMP:      item.key_byte = base + 8'(i * arg);
        GEN_ZERO_HEAD: item.key_byte = (i < arg) ? 8'h00 : base + 8'(i - arg);
        GEN_UNIFORM:   item.key_byte = 8'($urandom);
        GEN_ALPHABET:  item.key_byte = alphabet[$urandom_range(0, arg - 1)];
        default: begin
          item.key_byte = ($urandom_range(0, 99) < arg) ? 8'h00 : 8'($urandom);
        end
      endcase
      item.last_byte = (i == len - 1);
      send_byte(item, typed, typed_verdict);
    end
    keys_sent++;
  endtask

  // the block is idle once every verdict is back and the pipeline has drained
  task automatic settle_idle();
    in_valid   <= 1'b0;
    burst_left = 0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [kec_pkg::CFG_IDX_W-1:0] idx,
                           input logic [kec_pkg::CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == kec_pkg::CFG_MIN_ENTROPY) begin
      min_ratio = value;
    end else if (idx == kec_pkg::CFG_ZERO_LIMIT) begin
      zero_limit = value;
    end
  endtask

  task automatic program_phase(input int unsigned phase);
    logic [kec_pkg::CFG_DATA_W-1:0] ratio;
    logic [kec_pkg::CFG_DATA_W-1:0] limit;
    case (phase)
      0: begin ratio = 9'd0;    limit = 9'd0;            end
      1: begin ratio = 9'd256;  limit = 9'd256;          end
      2: begin ratio = 9'd511;  limit = 9'd511;          end
      // all-distinct keys sit exactly on the 160 boundary
      3: begin ratio = 9'd160;  limit = 9'(KEY_BYTES);   end
      4: begin ratio = 9'd161;  limit = 9'd1;            end
      5: begin ratio = kec_pkg::MIN_RATIO_RST; limit = kec_pkg::ZERO_LIMIT_RST; end
      default: begin
        ratio = 9'($urandom_range(0, 300));
        limit = 9'($urandom_range(0, 40));
      end
    endcase
    settle_idle();
    write_reg(kec_pkg::CFG_MIN_ENTROPY, ratio);
    write_reg((phase % 2 == 0) ? CFG_SPARE_A : CFG_SPARE_B, 9'($urandom));
    write_reg(kec_pkg::CFG_ZERO_LIMIT, limit);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // result side: check, then pick the next stall
  int unsigned   stall_mode;
  int unsigned   stall_left;
  kec_pkg::out_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        $error("verdict with nothing outstanding: status %0d zero_total %0d",
               out_data.status, out_data.zero_total);
        fail_count++;
      end else begin
        want = verdict_q.pop_front();
        status_seen[out_data.status]++;
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          fail_count++;
        end
        if (out_data.zero_total !== want.zero_total) begin
          $error("zero_total: expected %0d, got %0d", want.zero_total, out_data.zero_total);
          fail_count++;
        end
      end
    end
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(16, 80);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  initial begin
    int unsigned   rand_items;
    int unsigned   rand_keys;
    int unsigned   len;
    int unsigned   pick;
    key_gen_e      gen;
    int unsigned   arg;
    kec_pkg::out_t no_verdict;
    no_verdict = '0;
    rand_items = 0;
    rand_keys  = 0;
    for (int c = 0; c <= CNT_SAT; c++) begin
      clog_tab[c] = c_log_c(c);
    end
    clear_histogram();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    settings_used = 1;
    for (int r = 0; r < NUM_DIRECTED; r++) begin
      send_key(DIRECTED_KEYS[r].len, DIRECTED_KEYS[r].gen, DIRECTED_KEYS[r].base,
               DIRECTED_KEYS[r].arg, DIRECTED_KEYS[r].typed, DIRECTED_KEYS[r].verdict);
    end

    while (rand_items < RANDOM_ITEMS || rand_keys < MIN_RAND_KEYS) begin
      if (rand_keys % KEYS_PER_PHASE == 0) begin
        program_phase(rand_keys / KEYS_PER_PHASE);
      end
      len  = ($urandom_range(0, 3) != 0) ? KEY_BYTES : $urandom_range(1, KEY_BYTES + 9);
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
        gen = GEN_UNIFORM;   arg = 0;
      end else if (pick < 6) begin
        gen = GEN_ALPHABET;  arg = $urandom_range(1, 12);
      end else if (pick < 8) begin
        gen = GEN_ZERO_MIX;  arg = $urandom_range(0, 60);
      end else if (pick == 8) begin
        gen = GEN_RAMP;      arg = $urandom_range(0, 127) * 2 + 1;
      end else begin
        gen = GEN_ZERO_HEAD; arg = $urandom_range(0, 12);
      end
      send_key(len, gen, 8'($urandom), arg, 1'b0, no_verdict);
      rand_items += len;
      rand_keys++;
    end

    settle_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d keys, %0d key bytes, %0d register settings",
             keys_sent, bytes_sent, settings_used);
    $display("verdicts: %0d valid, %0d bad length, %0d zero bytes, %0d low entropy",
             status_seen[kec_pkg::STATUS_VALID], status_seen[kec_pkg::STATUS_BAD_LENGTH],
             status_seen[kec_pkg::STATUS_ZERO_BYTES],
             status_seen[kec_pkg::STATUS_LOW_ENTROPY]);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $error("timeout with %0d verdicts outstanding", verdict_q.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
